// ----- src/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared definitions
// Widths, pipeline depths, the arctangent table and the per-vector state
// carried by the vectoring cells.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int TABLE_LEN = 24;
   localparam int SQRT_STEPS = 29;
   localparam int TERM_W = 35;
   localparam int VEC_W = 40;
   localparam int ANG_W = 26;
   localparam int RAD_W = 57;
   localparam int ACC_W = 58;
   localparam int IDX_W = 5;
   localparam int HALF_TURN_UNITS = 23040;
   localparam int QUARTER_TURN_UNITS = 11520;
   localparam int HALF_TURN_ACC = 180 * 32768;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } vec_type;

   // atan(2^-i) in units of 2^-15 degree.
   function automatic logic signed [ANG_W-1:0] atan_step(input logic [IDX_W-1:0] i);
      logic [ANG_W-1:0] r;
      case (i)
         5'd0: r = 26'd1474560;
         5'd1: r = 26'd870484;
         5'd2: r = 26'd459940;
         5'd3: r = 26'd233473;
         5'd4: r = 26'd117189;
         5'd5: r = 26'd58652;
         5'd6: r = 26'd29333;
         5'd7: r = 26'd14667;
         5'd8: r = 26'd7334;
         5'd9: r = 26'd3667;
         5'd10: r = 26'd1833;
         5'd11: r = 26'd917;
         5'd12: r = 26'd458;
         5'd13: r = 26'd229;
         5'd14: r = 26'd115;
         5'd15: r = 26'd57;
         5'd16: r = 26'd29;
         5'd17: r = 26'd14;
         5'd18: r = 26'd7;
         5'd19: r = 26'd4;
         5'd20: r = 26'd2;
         5'd21: r = 26'd1;
         default: r = 26'd0;
      endcase
      return signed'(r);
   endfunction

   // Folds a vector into the right half plane and seeds the angle.
   function automatic vec_type vec_prep(input logic signed [VEC_W-1:0] y,
                                        input logic signed [VEC_W-1:0] x);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      if (x[VEC_W-1]) begin
         v.x = -x;
         v.y = -y;
         v.z = y[VEC_W-1] ? -ANG_W'(HALF_TURN_ACC) : ANG_W'(HALF_TURN_ACC);
      end else begin
         v.x = x;
         v.y = y;
         v.z = '0;
      end
      return v;
   endfunction

   // Rounds to 1/128 degree, half away from zero, and saturates to +-lim.
   function automatic logic signed [15:0] to_out(input vec_type v, input logic [15:0] lim);
      logic [ANG_W-1:0] mag;
      logic [ANG_W-1:0] r;
      logic [15:0]      m;
      logic signed [15:0] res;
      mag = v.z[ANG_W-1] ? ANG_W'(-v.z) : ANG_W'(v.z);
      r = (mag + ANG_W'(128)) >> 8;
      m = (r > ANG_W'(lim)) ? lim : r[15:0];
      res = v.z[ANG_W-1] ? -signed'(m) : signed'(m);
      if (v.zero) begin
         res = '0;
      end
      return res;
   endfunction

endpackage

// ----- src/qte_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One step of the restoring integer square root: takes two radicand bits
// per stage and hands the remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [qte_pkg::IDX_W-1:0]    step_k,
   input  logic [qte_pkg::RAD_W-1:0]    rem_in,
   input  logic [qte_pkg::ACC_W-1:0]    root_in,
   output logic [qte_pkg::RAD_W-1:0]    rem_out,
   output logic [qte_pkg::ACC_W-1:0]    root_out
);

   logic [qte_pkg::RAD_W-1:0] rem_ff;
   logic [qte_pkg::ACC_W-1:0] root_ff;
   logic [qte_pkg::RAD_W-1:0] rem_in_next;
   logic [qte_pkg::ACC_W-1:0] root_in_next;
   logic [qte_pkg::ACC_W-1:0] bit_val;
   logic [qte_pkg::ACC_W-1:0] trial;
   logic [qte_pkg::ACC_W-1:0] rem_ext;

   always_comb begin
      bit_val = qte_pkg::ACC_W'(1) << {step_k, 1'b0};
      trial = root_in + bit_val;
      rem_ext = {1'b0, rem_in};
      if (rem_ext >= trial) begin
         rem_in_next = qte_pkg::RAD_W'(rem_ext - trial);
         root_in_next = (root_in >> 1) + bit_val;
      end else begin
         rem_in_next = rem_in;
         root_in_next = root_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_next;
         root_ff <= root_in_next;
      end
   end

   assign rem_out = rem_ff;
   assign root_out = root_ff;

endmodule

// ----- src/qte_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// Vectoring cell
// One CORDIC vectoring micro-rotation, registered, for one vector.
// ----------------------------------------------------------------------------
module qte_cordic_cell (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [qte_pkg::IDX_W-1:0] step_i,
   input  qte_pkg::vec_type          vec_in,
   output qte_pkg::vec_type          vec_out
);

   qte_pkg::vec_type vec_ff;
   qte_pkg::vec_type vec_in_next;
   logic signed [qte_pkg::VEC_W-1:0] dx;
   logic signed [qte_pkg::VEC_W-1:0] dy;

   // Shift of the magnitude, so that negative values truncate toward zero.
   function automatic logic signed [qte_pkg::VEC_W-1:0] shr(
      input logic signed [qte_pkg::VEC_W-1:0] v, input logic [qte_pkg::IDX_W-1:0] s);
      logic [qte_pkg::VEC_W-1:0] mag;
      mag = v[qte_pkg::VEC_W-1] ? qte_pkg::VEC_W'(-v) : qte_pkg::VEC_W'(v);
      mag = mag >> s;
      return v[qte_pkg::VEC_W-1] ? -signed'(mag) : signed'(mag);
   endfunction

   always_comb begin
      dx = shr(vec_in.x, step_i);
      dy = shr(vec_in.y, step_i);
      vec_in_next.zero = vec_in.zero;
      if (vec_in.y > 0) begin
         vec_in_next.x = vec_in.x + dy;
         vec_in_next.y = vec_in.y - dx;
         vec_in_next.z = vec_in.z + qte_pkg::atan_step(step_i);
      end else begin
         vec_in_next.x = vec_in.x - dy;
         vec_in_next.y = vec_in.y + dx;
         vec_in_next.z = vec_in.z - qte_pkg::atan_step(step_i);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in_next;
      end
   end

   assign vec_out = vec_ff;

endmodule

// ----- src/quaternion_to_euler_angles_unit.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles unit
// Converts a Q2.14 quaternion to roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// The unit is fully pipelined and takes one quaternion every cycle. It has
// 3 + 29 + 1 + CORDIC_ITERATIONS + 1 = 50 register stages; the first is
// loaded at the transfer edge. The depth is set by the 29-cell square root
// row feeding the pitch arcsine and the 16-cell vectoring rows. The whole
// pipeline holds while a result waits on rsp_stall. Pitch saturates to +-90
// degrees with pitch_clamped set when the pitch sine reaches magnitude one.
module quaternion_to_euler_angles_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_deg,
   output logic signed [14:0] rsp_pitch_deg,
   output logic signed [15:0] rsp_yaw_deg,
   output logic               rsp_pitch_clamped
);

   localparam int NSQ = qte_pkg::SQRT_STEPS;
   localparam int NC = qte_pkg::CORDIC_ITERATIONS;
   localparam int TW = qte_pkg::TERM_W;
   localparam int DEPTH = 3 + NSQ + 1 + NC + 1;

   logic enable;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   assign enable = !(valid_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // Products.
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // Sine and cosine terms in Q28.
   logic signed [TW-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sr_ff <= (TW'(wx_ff) + TW'(yz_ff)) <<< 1;
         cr_ff <= TW'(1 << 28) - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
         sp_ff <= (TW'(wy_ff) - TW'(zx_ff)) <<< 1;
         sy_ff <= (TW'(wz_ff) + TW'(xy_ff)) <<< 1;
         cy_ff <= TW'(1 << 28) - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      end
   end

   // Clamp test and radicand of the pitch cosine. Outside the clamp the sine
   // magnitude is below 2^28, so its square is formed from the magnitude.
   logic signed [28:0] sp_short;
   logic [27:0] sp_mag;
   logic [55:0] sq;
   logic clamp_in;
   assign sp_short = sp_ff[28:0];
   assign sp_mag = sp_short[28] ? 28'(-sp_short) : sp_short[27:0];
   assign sq = sp_mag * sp_mag;
   assign clamp_in = (sp_ff >= TW'(1 << 28)) || (sp_ff <= -TW'(1 << 28));

   logic [qte_pkg::RAD_W-1:0] rad_ff;
   logic signed [TW-1:0] dsr_ff [NSQ+1];
   logic signed [TW-1:0] dcr_ff [NSQ+1];
   logic signed [TW-1:0] dsy_ff [NSQ+1];
   logic signed [TW-1:0] dcy_ff [NSQ+1];
   logic signed [TW-1:0] dsp_ff [NSQ+1];
   logic                 dcl_ff [NSQ+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff <= qte_pkg::RAD_W'((58'(1) << 56) - sq);
         dsr_ff[0] <= sr_ff;
         dcr_ff[0] <= cr_ff;
         dsy_ff[0] <= sy_ff;
         dcy_ff[0] <= cy_ff;
         dsp_ff[0] <= sp_ff;
         dcl_ff[0] <= clamp_in;
         for (int j = 1; j <= NSQ; j++) begin
            dsr_ff[j] <= dsr_ff[j-1];
            dcr_ff[j] <= dcr_ff[j-1];
            dsy_ff[j] <= dsy_ff[j-1];
            dcy_ff[j] <= dcy_ff[j-1];
            dsp_ff[j] <= dsp_ff[j-1];
            dcl_ff[j] <= dcl_ff[j-1];
         end
      end
   end

   // Square root row.
   logic [qte_pkg::RAD_W-1:0] rem_w  [NSQ+1];
   logic [qte_pkg::ACC_W-1:0] root_w [NSQ+1];
   assign rem_w[0] = rad_ff;
   assign root_w[0] = '0;

   for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock    (clock),
         .enable   (enable),
         .step_k   (qte_pkg::IDX_W'(NSQ - 1 - j)),
         .rem_in   (rem_w[j]),
         .root_in  (root_w[j]),
         .rem_out  (rem_w[j+1]),
         .root_out (root_w[j+1])
      );
   end

   // Fold into the right half plane.
   qte_pkg::vec_type roll_v [NC+1];
   qte_pkg::vec_type yaw_v  [NC+1];
   qte_pkg::vec_type ptch_v [NC+1];
   logic cl_ff [NC+1];
   logic ps_ff [NC+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         roll_v[0] <= qte_pkg::vec_prep(qte_pkg::VEC_W'(dsr_ff[NSQ]),
                                        qte_pkg::VEC_W'(dcr_ff[NSQ]));
         yaw_v[0] <= qte_pkg::vec_prep(qte_pkg::VEC_W'(dsy_ff[NSQ]),
                                       qte_pkg::VEC_W'(dcy_ff[NSQ]));
         ptch_v[0] <= qte_pkg::vec_prep(qte_pkg::VEC_W'(dsp_ff[NSQ]),
                                        qte_pkg::VEC_W'(signed'(root_w[NSQ])));
         cl_ff[0] <= dcl_ff[NSQ];
         ps_ff[0] <= dsp_ff[NSQ][TW-1];
         for (int j = 1; j <= NC; j++) begin
            cl_ff[j] <= cl_ff[j-1];
            ps_ff[j] <= ps_ff[j-1];
         end
      end
   end

   for (genvar j = 0; j < NC; j++) begin : g_cordic
      qte_cordic_cell u_roll (
         .clock (clock), .enable (enable), .step_i (qte_pkg::IDX_W'(j)),
         .vec_in (roll_v[j]), .vec_out (roll_v[j+1])
      );
      qte_cordic_cell u_yaw (
         .clock (clock), .enable (enable), .step_i (qte_pkg::IDX_W'(j)),
         .vec_in (yaw_v[j]), .vec_out (yaw_v[j+1])
      );
      qte_cordic_cell u_pitch (
         .clock (clock), .enable (enable), .step_i (qte_pkg::IDX_W'(j)),
         .vec_in (ptch_v[j]), .vec_out (ptch_v[j+1])
      );
   end

   // Output register.
   logic signed [15:0] roll_ff, yaw_ff;
   logic signed [14:0] pitch_ff;
   logic               clamped_ff;
   logic signed [15:0] pitch_full;

   assign pitch_full = qte_pkg::to_out(ptch_v[NC], 16'(qte_pkg::QUARTER_TURN_UNITS));

   always_ff @(posedge clock) begin
      if (enable) begin
         roll_ff <= qte_pkg::to_out(roll_v[NC], 16'(qte_pkg::HALF_TURN_UNITS));
         yaw_ff <= qte_pkg::to_out(yaw_v[NC], 16'(qte_pkg::HALF_TURN_UNITS));
         clamped_ff <= cl_ff[NC];
         if (cl_ff[NC]) begin
            pitch_ff <= ps_ff[NC] ? -15'(qte_pkg::QUARTER_TURN_UNITS)
                                  : 15'(qte_pkg::QUARTER_TURN_UNITS);
         end else begin
            pitch_ff <= pitch_full[14:0];
         end
      end
   end

   assign rsp_roll_deg = roll_ff;
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_yaw_deg = yaw_ff;
   assign rsp_pitch_clamped = clamped_ff;

endmodule
